>>> rtl/core/irc_message_tokenizer_defines.svh
// Assertion macros used by the tokenizer result queue.
`ifndef IRC_MESSAGE_TOKENIZER_DEFINES_SVH
`define IRC_MESSAGE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define IRC_TOK_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define IRC_TOK_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/irc_tok_pkg.sv
// Types, kind codes and command tables shared by the IRC tokenizer modules.
`timescale 1ns / 1ps

package irc_tok_pkg;

   localparam int unsigned MSG_BYTES_DEFAULT = 512;
   localparam int unsigned NUM_CMDS          = 10;
   localparam int unsigned CMD_TEXT_MAX      = 8;

   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   typedef enum logic [4:0] {
      KIND_END, KIND_HASH, KIND_COMMA, KIND_PLUS, KIND_MINUS, KIND_CRLF,
      KIND_CR, KIND_LF, KIND_SPACE, KIND_COLON, KIND_WORD,
      KIND_PASS, KIND_NICK, KIND_USER, KIND_JOIN, KIND_KICK,
      KIND_INVITE, KIND_TOPIC, KIND_MODE, KIND_PRIVMSG, KIND_NOTICE
   } kind_type;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [8:0] start_offset;
      logic [9:0] token_length;
      logic       overflowed;
      logic       last_of_run;
   } rsp_type;

   // Up to two tokens produced by one accepted item; valid1 implies valid0.
   typedef struct packed {
      logic    valid0;
      logic    valid1;
      rsp_type slot0;
      rsp_type slot1;
   } push_type;

   // Command names in kind order, padded with zero bytes.
   localparam logic [7:0] CMD_TEXT [NUM_CMDS][CMD_TEXT_MAX] = '{
      '{"P", "A", "S", "S", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"N", "I", "C", "K", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"U", "S", "E", "R", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"J", "O", "I", "N", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"K", "I", "C", "K", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"I", "N", "V", "I", "T", "E", 8'h00, 8'h00},
      '{"T", "O", "P", "I", "C", 8'h00, 8'h00, 8'h00},
      '{"M", "O", "D", "E", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "R", "I", "V", "M", "S", "G", 8'h00},
      '{"N", "O", "T", "I", "C", "E", 8'h00, 8'h00}
   };

   localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{
      4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd6, 4'd5, 4'd4, 4'd7, 4'd6
   };

endpackage

>>> rtl/core/irc_tok_lexer.sv
// Lexer state and the combinational token decision for one accepted item.
`timescale 1ns / 1ps

module irc_tok_lexer import irc_tok_pkg::*; #(
   parameter int unsigned MSG_BYTES = MSG_BYTES_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req,
   output push_type push
);

   localparam int unsigned POS_W   = $clog2(MSG_BYTES + 1);
   localparam int unsigned BEGIN_W = $clog2(MSG_BYTES);
   localparam logic [POS_W-1:0]   POS_LIMIT  = POS_W'(MSG_BYTES);
   localparam logic [BEGIN_W-1:0] BEGIN_LAST = BEGIN_W'(MSG_BYTES - 1);

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   logic                in_word_ff,    in_word_in;
   logic [BEGIN_W-1:0]  word_begin_ff, word_begin_in;
   logic [POS_W-1:0]    word_count_ff, word_count_in;
   logic [NUM_CMDS-1:0] cand_ff,       cand_in;
   logic                cr_pending_ff, cr_pending_in;
   logic [POS_W-1:0]    pos_ff,        pos_in;
   logic                overflow_ff,   overflow_in;

   logic [7:0]          data_byte;
   logic                pk_valid;
   kind_type            pk_kind;
   kind_type            word_kind;
   logic [NUM_CMDS-1:0] fed_cand;
   logic [NUM_CMDS-1:0] first_cand;
   logic [POS_W-1:0]    count_inc;
   logic                ovf_now;
   logic                ovf_new;
   logic [BEGIN_W-1:0]  offset;
   logic                do_start;
   logic                pre_valid;
   logic                ts_valid;
   rsp_type             pre_tok;
   rsp_type             ts_tok;

   function automatic rsp_type make_tok(kind_type k, logic [31:0] start,
                                        logic [31:0] len, logic ovf);
      rsp_type r;
      r.kind         = k;
      r.start_offset = start[8:0];
      r.token_length = len[9:0];
      r.overflowed   = ovf;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   assign data_byte = req.data_byte;

   // Single-character punctuation.
   always_comb begin
      pk_valid = 1'b1;
      pk_kind  = KIND_END;
      case (data_byte)
         CHAR_HASH:  pk_kind = KIND_HASH;
         CHAR_COMMA: pk_kind = KIND_COMMA;
         CHAR_PLUS:  pk_kind = KIND_PLUS;
         CHAR_MINUS: pk_kind = KIND_MINUS;
         CHAR_LF:    pk_kind = KIND_LF;
         CHAR_SPACE: pk_kind = KIND_SPACE;
         CHAR_COLON: pk_kind = KIND_COLON;
         default:    pk_valid = 1'b0;
      endcase
   end

   // Command matching: one comparator per command, all in parallel.
   always_comb begin
      word_kind = KIND_WORD;
      for (int i = NUM_CMDS - 1; i >= 0; i--) begin
         fed_cand[i]   = cand_ff[i] && (word_count_ff < POS_W'(CMD_LEN[i])) &&
                         (CMD_TEXT[i][word_count_ff[2:0]] == data_byte);
         first_cand[i] = (CMD_TEXT[i][0] == data_byte);
         if (cand_ff[i] && (word_count_ff == POS_W'(CMD_LEN[i]))) begin
            word_kind = kind_type'(5'(KIND_PASS) + 5'(i));
         end
      end
   end

   assign count_inc = (word_count_ff < POS_LIMIT) ? word_count_ff + POS_W'(1)
                                                  : word_count_ff;
   assign ovf_now   = (pos_ff >= POS_LIMIT);
   assign ovf_new   = overflow_ff | ovf_now;
   assign offset    = ovf_now ? BEGIN_LAST : pos_ff[BEGIN_W-1:0];

   always_comb begin
      in_word_in    = in_word_ff;
      word_begin_in = word_begin_ff;
      word_count_in = word_count_ff;
      cand_in       = cand_ff;
      cr_pending_in = cr_pending_ff;
      pos_in        = pos_ff;
      overflow_in   = overflow_ff;
      do_start      = 1'b0;
      pre_valid     = 1'b0;
      ts_valid      = 1'b0;
      pre_tok       = make_tok(KIND_END, 32'd0, 32'd0, 1'b0);
      ts_tok        = make_tok(KIND_END, 32'd0, 32'd0, 1'b0);

      if (req.action == ACTION_END) begin
         // Flush whatever is open, close with the end token, then restart.
         if (in_word_ff) begin
            pre_valid = 1'b1;
            pre_tok   = make_tok(word_kind, 32'(word_begin_ff),
                                 32'(word_count_ff), overflow_ff);
         end else if (cr_pending_ff) begin
            pre_valid = 1'b1;
            pre_tok   = make_tok(KIND_CR, 32'(word_begin_ff), 32'd1, overflow_ff);
         end
         ts_valid      = 1'b1;
         ts_tok        = make_tok(KIND_END, 32'd0, 32'd0, overflow_ff);
         in_word_in    = 1'b0;
         word_begin_in = '0;
         word_count_in = '0;
         cand_in       = '1;
         cr_pending_in = 1'b0;
         pos_in        = '0;
         overflow_in   = 1'b0;
      end else begin
         overflow_in = ovf_new;
         if (!ovf_now) begin
            pos_in = pos_ff + POS_W'(1);
         end

         if (cr_pending_ff) begin
            cr_pending_in = 1'b0;
            pre_valid     = 1'b1;
            if (data_byte == CHAR_LF) begin
               pre_tok = make_tok(KIND_CRLF, 32'(word_begin_ff), 32'd2, ovf_new);
            end else begin
               pre_tok  = make_tok(KIND_CR, 32'(word_begin_ff), 32'd1, ovf_new);
               do_start = 1'b1;
            end
         end else if (in_word_ff) begin
            if (!(pk_valid || data_byte == CHAR_CR || data_byte == CHAR_AMP)) begin
               cand_in       = fed_cand;
               word_count_in = count_inc;
            end else begin
               pre_valid  = 1'b1;
               pre_tok    = make_tok(word_kind, 32'(word_begin_ff),
                                     32'(word_count_ff), ovf_new);
               in_word_in = 1'b0;
               do_start   = 1'b1;
            end
         end else begin
            do_start = 1'b1;
         end

         if (do_start) begin
            if (data_byte == CHAR_NUL) begin
               // A NUL where a token would begin is dropped.
            end else if (pk_valid) begin
               ts_valid = 1'b1;
               ts_tok   = make_tok(pk_kind, 32'(offset), 32'd1, ovf_new);
            end else if (data_byte == CHAR_CR) begin
               cr_pending_in = 1'b1;
               word_begin_in = offset;
            end else begin
               in_word_in    = 1'b1;
               word_begin_in = offset;
               word_count_in = POS_W'(1);
               cand_in       = first_cand;
            end
         end
      end
   end

   always_comb begin
      push.valid0 = accept && (pre_valid || ts_valid);
      push.valid1 = accept && pre_valid && ts_valid;
      push.slot0  = pre_valid ? pre_tok : ts_tok;
      push.slot0.last_of_run = !(pre_valid && ts_valid);
      push.slot1  = ts_tok;
      push.slot1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff    <= 1'b0;
         word_begin_ff <= '0;
         word_count_ff <= '0;
         cand_ff       <= '1;
         cr_pending_ff <= 1'b0;
         pos_ff        <= '0;
         overflow_ff   <= 1'b0;
      end else if (accept) begin
         in_word_ff    <= in_word_in;
         word_begin_ff <= word_begin_in;
         word_count_ff <= word_count_in;
         cand_ff       <= cand_in;
         cr_pending_ff <= cr_pending_in;
         pos_ff        <= pos_in;
         overflow_ff   <= overflow_in;
      end
   end

endmodule

>>> rtl/core/irc_tok_fifo.sv
// Four-entry result queue: takes up to two tokens, releases one per cycle unless stalled.
`timescale 1ns / 1ps
`include "irc_message_tokenizer_defines.svh"

module irc_tok_fifo import irc_tok_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     has_room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload
);

   rsp_type    entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff,  count_in;
   logic       pop;
   logic [2:0] push_n;

   assign has_room    = (count_ff <= 3'd2);
   assign rsp_valid   = (count_ff != 3'd0);
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign push_n      = {2'b00, push.valid0} + {2'b00, push.valid1};
   assign wr_ptr_in   = wr_ptr_ff + push_n[1:0];
   assign rd_ptr_in   = rd_ptr_ff + {1'b0, pop};
   assign count_in    = count_ff + push_n - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         entry_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.valid1) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `IRC_TOK_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= 3'd4, "queue count above depth")
   `IRC_TOK_ASSERT_NOW(a_push_room, push.valid0, count_ff <= 3'd2, "push without room")
   `IRC_TOK_ASSERT_NEXT(a_pop_drains, pop && !push.valid0,
                        count_ff == 3'($past(count_ff) - 3'd1), "pop did not drain")

endmodule

>>> rtl/core/irc_message_tokenizer.sv
// Top level of the streaming IRC message tokenizer.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake             Payload
//  req_      in         req_valid/req_stall   req_type: action, data_byte
//  rsp_      out        rsp_valid/rsp_stall   rsp_type: kind, start_offset,
//                                             token_length, overflowed, last_of_run
//
// One item is accepted per cycle while req_stall is low. Its tokens are decided
// in the same cycle and land in a four-entry result queue; if the queue was empty,
// the first one shows on rsp_ the next cycle. An item yields zero, one or two
// tokens; the queue drains one token per cycle while rsp_stall is low, and
// req_stall rises while it holds more than two, which slows two-token items.
// Synchronous reset clears the lexer state and empties the queue.

module irc_message_tokenizer import irc_tok_pkg::*; #(
   parameter int unsigned MSG_BYTES = MSG_BYTES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // The lexer only advances on an accepted item; every token it decides for
   // that item is written into the queue in the same edge.
   logic     accept;
   logic     has_room;
   push_type push;

   // Room for two tokens is required so that a two-token item is never split.
   assign req_stall = !has_room;
   assign accept    = req_valid && has_room;

   irc_tok_lexer #(
      .MSG_BYTES(MSG_BYTES)
   ) u_lexer (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .push   (push)
   );

   // The queue parts the two sides: a waiting token never holds back input
   // while there is room for two more tokens behind it.
   irc_tok_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .has_room    (has_room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> dv/tb_irc_message_tokenizer.sv
// Self-checking testbench for irc_message_tokenizer with random idling on both channels.
`timescale 1ns / 1ps

module tb_irc_message_tokenizer;
   import irc_tok_pkg::*;

   // Offsets saturate at MSG_LIMIT-1 and lengths at MSG_LIMIT, as with the default build.
   localparam int unsigned MSG_LIMIT   = MSG_BYTES_DEFAULT;
   localparam int          CMD_COUNT   = 10;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          SHORT_ITEMS = 700;
   localparam int          LONG_WORD   = 530;
   localparam int          MAX_PRINTED = 100;

   // Byte values that the lexer treats specially, plus letters and 0xFF for directed tests.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZED   = 8'h5A;
   localparam logic [7:0] CH_KAY   = 8'h4B;
   localparam logic [7:0] CH_HIGH  = 8'hFF;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   // The scoreboard tracks the lexer state of the message in flight and keeps the
   // tokens that each accepted item must produce, oldest first.
   class token_scoreboard;
      rsp_type     expected_tokens[$];
      int          mismatches;
      string       cmd_names[CMD_COUNT];
      bit          in_word;
      logic [8:0]  word_begin;
      logic [9:0]  word_count;
      logic [9:0]  candidates;
      bit          cr_pending;
      logic [9:0]  byte_pos;
      bit          overflow_seen;

      function new();
         cmd_names = '{"PASS", "NICK", "USER", "JOIN", "KICK",
                       "INVITE", "TOPIC", "MODE", "PRIVMSG", "NOTICE"};
         mismatches = 0;
         clear_lexer();
      endfunction

      function void clear_lexer();
         in_word       = 1'b0;
         word_begin    = '0;
         word_count    = '0;
         candidates    = '1;
         cr_pending    = 1'b0;
         byte_pos      = '0;
         overflow_seen = 1'b0;
      endfunction

      function bit is_sep(input logic [7:0] b);
         return b inside {CH_AMP, CH_HASH, CH_COMMA, CH_PLUS, CH_MINUS,
                          CH_CR, CH_LF, CH_SPACE, CH_COLON};
      endfunction

      // Single-byte punctuation; returns 0 for any other byte.
      function bit punct_kind(input logic [7:0] b, output kind_type k);
         k = KIND_END;
         case (b)
            CH_HASH:  k = KIND_HASH;
            CH_COMMA: k = KIND_COMMA;
            CH_PLUS:  k = KIND_PLUS;
            CH_MINUS: k = KIND_MINUS;
            CH_LF:    k = KIND_LF;
            CH_SPACE: k = KIND_SPACE;
            CH_COLON: k = KIND_COLON;
            default:  return 1'b0;
         endcase
         return 1'b1;
      endfunction

      function void push_token(input kind_type k, input int unsigned start,
                               input int unsigned len);
         rsp_type t;
         t.kind         = k;
         t.start_offset = 9'(start);
         t.token_length = 10'(len);
         t.overflowed   = overflow_seen;
         t.last_of_run  = 1'b0;
         expected_tokens.push_back(t);
      endfunction

      // Narrows the set of command names that still match the word so far.
      function void absorb_word_byte(input logic [7:0] b);
         for (int i = 0; i < CMD_COUNT; i++) begin
            if (candidates[i] && (word_count >= cmd_names[i].len() ||
                                  cmd_names[i][word_count] != b)) begin
               candidates[i] = 1'b0;
            end
         end
         if (word_count < MSG_LIMIT) begin
            word_count++;
         end
      endfunction

      function kind_type word_kind();
         for (int i = 0; i < CMD_COUNT; i++) begin
            if (candidates[i] && cmd_names[i].len() == word_count) begin
               return kind_type'(KIND_PASS + i);
            end
         end
         return KIND_WORD;
      endfunction

      // Works out the tokens caused by one accepted item.
      function void note_item(input req_type it);
         kind_type    pk;
         int unsigned off;
         int          before_count;
         logic [7:0]  b;
         bit          handled;
         rsp_type     t;
         before_count = expected_tokens.size();
         handled      = 1'b0;
         b            = it.data_byte;
         if (it.action == ACTION_END) begin
            if (in_word) begin
               push_token(word_kind(), word_begin, word_count);
            end else if (cr_pending) begin
               push_token(KIND_CR, word_begin, 1);
            end
            push_token(KIND_END, 0, 0);
            clear_lexer();
         end else begin
            if (byte_pos >= MSG_LIMIT) begin
               overflow_seen = 1'b1;
               off = MSG_LIMIT - 1;
            end else begin
               off = byte_pos;
               byte_pos++;
            end
            if (cr_pending) begin
               cr_pending = 1'b0;
               if (b == CH_LF) begin
                  push_token(KIND_CRLF, word_begin, 2);
                  handled = 1'b1;
               end else begin
                  push_token(KIND_CR, word_begin, 1);
               end
            end else if (in_word) begin
               if (!is_sep(b)) begin
                  absorb_word_byte(b);
                  handled = 1'b1;
               end else begin
                  push_token(word_kind(), word_begin, word_count);
                  in_word = 1'b0;
               end
            end
            // Token start: NUL is dropped, CR waits for a possible LF.
            if (!handled) begin
               if (b == CH_NUL) begin
               end else if (punct_kind(b, pk)) begin
                  push_token(pk, off, 1);
               end else if (b == CH_CR) begin
                  cr_pending = 1'b1;
                  word_begin = 9'(off);
               end else begin
                  in_word    = 1'b1;
                  word_begin = 9'(off);
                  word_count = '0;
                  candidates = '1;
                  absorb_word_byte(b);
               end
            end
         end
         if (expected_tokens.size() > before_count) begin
            t = expected_tokens.pop_back();
            t.last_of_run = 1'b1;
            expected_tokens.push_back(t);
         end
      endfunction

      task report(input string what);
         mismatches++;
         if (mismatches <= MAX_PRINTED) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
         end
      endtask

      task check_token(input rsp_type got);
         rsp_type want;
         if (expected_tokens.size() == 0) begin
            report($sformatf("token kind %0d offset %0d with nothing expected",
                             got.kind, got.start_offset));
            return;
         end
         want = expected_tokens.pop_front();
         if (got.kind != want.kind)
            report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
         if (got.start_offset != want.start_offset)
            report($sformatf("start_offset %0d, expected %0d",
                             got.start_offset, want.start_offset));
         if (got.token_length != want.token_length)
            report($sformatf("token_length %0d, expected %0d",
                             got.token_length, want.token_length));
         if (got.overflowed != want.overflowed)
            report($sformatf("overflowed %0b, expected %0b",
                             got.overflowed, want.overflowed));
         if (got.last_of_run != want.last_of_run)
            report($sformatf("last_of_run %0b, expected %0b",
                             got.last_of_run, want.last_of_run));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   token_scoreboard sb;
   logic [7:0]      msg_bytes[$];
   int              burst_left;
   int              items_sent;
   int              cycles;
   stall_mode_type  stall_mode;
   int              stall_left;
   int              stall_phase;

   irc_message_tokenizer uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake or lost token ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // The receiver picks a new stall behavior whenever its current stretch runs out: open
   // stretches, light random stalls, a fixed periodic stall, and heavy random stalls.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 80);
      end
      stall_left  = stall_left - 1;
      stall_phase = stall_phase + 1;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_PERIODIC: rsp_stall <= (stall_phase % 3 == 0);
         default:        rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   // Every accepted token is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_token(rsp_payload);
      end
   end

   // Offers one item and holds it until the block takes it. The sender works in
   // bursts; between bursts valid usually drops for a random gap.
   task automatic send_item(input logic act, input logic [7:0] b);
      req_type it;
      int      gap;
      it.action    = act;
      it.data_byte = b;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_payload <= it;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_item(it);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(ACTION_BYTE, b);
   endtask

   // The end marker ignores its data byte, so that byte is random.
   task automatic send_end();
      send_item(ACTION_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_message();
      foreach (msg_bytes[i]) begin
         send_byte(msg_bytes[i]);
      end
      send_end();
      msg_bytes.delete();
   endtask

   // Word bytes lean toward capitals so that command prefixes come up often, but
   // any byte that does not end a word can appear, NUL and high bytes included.
   function automatic logic [7:0] word_byte();
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: b = 8'($urandom_range(8'h41, 8'h5A));
         5, 6:          b = 8'($urandom_range(8'h61, 8'h7A));
         default: begin
            do b = 8'($urandom_range(0, 255)); while (sb.is_sep(b));
         end
      endcase
      return b;
   endfunction

   function automatic void add_command_variant();
      string name;
      int    len;
      name = sb.cmd_names[$urandom_range(0, CMD_COUNT - 1)];
      len  = name.len();
      case ($urandom_range(0, 3))
         0: begin
            // Exact command name.
            for (int i = 0; i < len; i++) msg_bytes.push_back(name[i]);
         end
         1: begin
            // Prefix one byte short.
            for (int i = 0; i < len - 1; i++) msg_bytes.push_back(name[i]);
         end
         2: begin
            // Lower-case first letter, which must not match.
            msg_bytes.push_back(name[0] + 8'h20);
            for (int i = 1; i < len; i++) msg_bytes.push_back(name[i]);
         end
         default: begin
            // One byte too long.
            for (int i = 0; i < len; i++) msg_bytes.push_back(name[i]);
            msg_bytes.push_back(word_byte());
         end
      endcase
   endfunction

   function automatic void add_separator();
      logic [7:0] puncts[7];
      puncts = '{CH_HASH, CH_COMMA, CH_PLUS, CH_MINUS, CH_SPACE, CH_COLON, CH_LF};
      case ($urandom_range(0, 5))
         0: msg_bytes.push_back(puncts[$urandom_range(0, 6)]);
         1: msg_bytes.push_back(CH_AMP);
         2: msg_bytes.push_back(CH_CR);
         3: begin
            msg_bytes.push_back(CH_CR);
            msg_bytes.push_back(CH_LF);
         end
         4: msg_bytes.push_back(CH_NUL);
         default: begin
            msg_bytes.push_back(CH_CR);
            msg_bytes.push_back(8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   // Builds a message shaped like IRC traffic: commands, words and separators,
   // often with a space between, and sometimes a plain run of noise bytes.
   function automatic void build_message();
      int pick;
      int count;
      if ($urandom_range(0, 9) == 0) begin
         count = $urandom_range(0, 20);
         repeat (count) msg_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      count = $urandom_range(1, 10);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            add_command_variant();
         end else if (pick < 60) begin
            repeat ($urandom_range(1, 8)) msg_bytes.push_back(word_byte());
         end else if (pick < 92) begin
            add_separator();
         end else begin
            msg_bytes.push_back(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 9) < 4) msg_bytes.push_back(CH_SPACE);
      end
   endfunction

   initial begin
      int long_at;
      bit long_done;
      sb          = new();
      burst_left  = 0;
      items_sent  = 0;
      cycles      = 0;
      stall_mode  = STALL_NONE;
      stall_left  = 0;
      stall_phase = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      rsp_stall   <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A NUL at a token start is dropped, then each punctuation
      // byte stands alone.
      send_byte(CH_NUL);
      send_byte(CH_HASH);
      send_byte(CH_COMMA);
      send_byte(CH_PLUS);
      send_byte(CH_MINUS);
      send_byte(CH_SPACE);
      send_byte(CH_COLON);
      send_byte(CH_LF);
      // CR then LF merges into one token; CR then punctuation gives two.
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(CH_CR);
      send_byte(CH_HASH);
      // Ampersand ends a word and starts the next one; NUL and 0xFF inside a
      // word are ordinary bytes; the comma then ends the word and stands alone.
      send_byte(CH_KAY);
      send_byte(CH_AMP);
      send_byte(CH_NUL);
      send_byte(CH_HIGH);
      send_byte(CH_COMMA);
      // CR before CR, then the end marker flushes the pending CR.
      send_byte(CH_CR);
      send_byte(CH_CR);
      send_end();
      // An empty message, then a word flushed by the end marker.
      send_end();
      send_byte(CH_ZED);
      send_end();

      // Random part, with one message long enough to overflow the buffer and
      // saturate both the offsets and a word length. It starts early enough
      // that it fits within the planned number of items.
      long_at   = $urandom_range(0, SHORT_ITEMS - LONG_WORD - 20);
      long_done = 1'b0;
      while (items_sent < SHORT_ITEMS) begin
         if (!long_done && items_sent >= long_at) begin
            long_done = 1'b1;
            repeat (LONG_WORD) msg_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
            msg_bytes.push_back(CH_SPACE);
            add_command_variant();
            msg_bytes.push_back(CH_CR);
            msg_bytes.push_back(CH_LF);
         end else begin
            build_message();
         end
         send_message();
      end
      req_valid <= 1'b0;

      // Drain, then let the result queue run on to show anything extra.
      while (sb.expected_tokens.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/irc_tok_pkg.sv
rtl/core/irc_tok_lexer.sv
rtl/core/irc_tok_fifo.sv
rtl/core/irc_message_tokenizer.sv
dv/tb_irc_message_tokenizer.sv
